>>> hw/rtl/irff_pkg.sv
package irff_pkg;

    localparam int ROOM_INDEX_W = 4;
    localparam int ROOMS_USE_W  = 5;
    localparam int M_TDATA_W    = 16;
    localparam int M_TUSER_W    = 2;

    typedef struct packed {
        logic [ROOM_INDEX_W-1:0] room_index;
        logic                    opened_new;
        logic                    no_room;
        logic [ROOMS_USE_W-1:0]  rooms_in_use;
    } result_t;

    typedef struct packed {
        logic valid;
    } queue_ctl_t;

endpackage

>>> hw/rtl/irff_ram.sv
module irff_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/irff_front.sv
module irff_front
    import irff_pkg::*;
#(
    parameter int TIME_WIDTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [TIME_WIDTH-1:0]   in_start,
    input  logic [TIME_WIDTH-1:0]   in_finish,
    input  logic                    q_pop,
    output queue_ctl_t              q_ctl,
    output logic [TIME_WIDTH-1:0]   q_start,
    output logic [TIME_WIDTH-1:0]   q_finish
);

    logic [2*TIME_WIDTH-1:0] slot_reg [2];
    logic                    wr_ptr_reg, wr_ptr_next;
    logic                    rd_ptr_reg, rd_ptr_next;
    logic [1:0]              fill_reg, fill_next;
    logic                    push;
    logic                    pop;

    assign in_ready = (fill_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && (fill_reg != 2'd0);

    assign q_ctl.valid = (fill_reg != 2'd0);
    assign q_start     = slot_reg[rd_ptr_reg][TIME_WIDTH-1:0];
    assign q_finish    = slot_reg[rd_ptr_reg][2*TIME_WIDTH-1:TIME_WIDTH];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= {in_finish, in_start};
        end
    end

endmodule

>>> hw/rtl/irff_back.sv
module irff_back
    import irff_pkg::*;
#(
    parameter int MAX_ROOMS  = 16,
    parameter int TIME_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  queue_ctl_t            q_ctl,
    output logic                  q_pop,
    input  logic [TIME_WIDTH-1:0] q_start,
    input  logic [TIME_WIDTH-1:0] q_finish,
    output logic                  res_valid,
    input  logic                  res_ready,
    output result_t               res
);

    localparam int IDX_W = $clog2(MAX_ROOMS);
    localparam int CNT_W = $clog2(MAX_ROOMS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [TIME_WIDTH-1:0] start_reg, start_next;
    logic [TIME_WIDTH-1:0] finish_reg, finish_next;
    result_t               pend_reg, pend_next;
    logic                  m_valid_reg, m_valid_next;
    result_t               m_res_reg, m_res_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [TIME_WIDTH-1:0] ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [TIME_WIDTH-1:0] ram_rdata;

    irff_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (MAX_ROOMS)
    ) u_finish_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        logic [31:0] idx_wide;
        logic [31:0] cnt_wide;
        logic [31:0] cnt_inc_wide;

        state_next   = state_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        start_next   = start_reg;
        finish_next  = finish_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_wdata    = finish_reg;
        ram_raddr    = idx_reg;
        idx_wide     = 32'(idx_reg);
        cnt_wide     = 32'(count_reg);
        cnt_inc_wide = 32'(count_reg) + 32'd1;

        if (m_valid_reg && res_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_ctl.valid) begin
                    q_pop       = 1'b1;
                    start_next  = q_start;
                    finish_next = q_finish;
                    idx_next    = '0;
                    ram_raddr   = '0;
                    if (count_reg == '0) begin
                        ram_we                 = 1'b1;
                        ram_waddr              = '0;
                        ram_wdata              = q_finish;
                        count_next             = CNT_W'(1);
                        pend_next.room_index   = '0;
                        pend_next.opened_new   = 1'b1;
                        pend_next.no_room      = 1'b0;
                        pend_next.rooms_in_use = ROOMS_USE_W'(1);
                        state_next             = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (start_reg >= ram_rdata) begin
                    ram_we                 = 1'b1;
                    ram_waddr              = idx_reg;
                    pend_next.room_index   = idx_wide[ROOM_INDEX_W-1:0];
                    pend_next.opened_new   = 1'b0;
                    pend_next.no_room      = 1'b0;
                    pend_next.rooms_in_use = cnt_wide[ROOMS_USE_W-1:0];
                    state_next             = ST_DONE;
                end else if (CNT_W'(idx_reg) + CNT_W'(1) == count_reg) begin
                    if (count_reg != CNT_W'(MAX_ROOMS)) begin
                        ram_we                 = 1'b1;
                        ram_waddr              = count_reg[IDX_W-1:0];
                        count_next             = count_reg + CNT_W'(1);
                        pend_next.room_index   = cnt_wide[ROOM_INDEX_W-1:0];
                        pend_next.opened_new   = 1'b1;
                        pend_next.no_room      = 1'b0;
                        pend_next.rooms_in_use = cnt_inc_wide[ROOMS_USE_W-1:0];
                    end else begin
                        pend_next.room_index   = '0;
                        pend_next.opened_new   = 1'b0;
                        pend_next.no_room      = 1'b1;
                        pend_next.rooms_in_use = cnt_wide[ROOMS_USE_W-1:0];
                    end
                    state_next = ST_DONE;
                end else begin
                    idx_next  = idx_reg + IDX_W'(1);
                    ram_raddr = idx_reg + IDX_W'(1);
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || res_ready) begin
                    m_valid_next = 1'b1;
                    m_res_next   = pend_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        start_reg  <= start_next;
        finish_reg <= finish_next;
        pend_reg   <= pend_next;
        m_res_reg  <= m_res_next;
    end

    assign res_valid = m_valid_reg;
    assign res       = m_res_reg;

endmodule

>>> hw/rtl/interval_room_first_fit.sv
// Channel | Direction | tdata (low bit up)                  | tuser (low bit up)
// s_      | in        | start_time, end_time, zero pad      | -
// m_      | out       | room_index, rooms_in_use, zero pad  | opened_new, no_room
//
// The back end scans open rooms from index 0 for the first whose finish time is at or
// before the start, else opens a new room or rejects; with no room open it opens room 0.
// A two-entry queue takes transfers while the back end scans or the result waits.
// Reset is synchronous on aresetn low; room count clears, finish times need no clear.
// A stalled m_ side holds the result; the queue then fills and drops s_tready.
module interval_room_first_fit
    import irff_pkg::*;
#(
    parameter int MAX_ROOMS  = 16,
    parameter int TIME_WIDTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((2*TIME_WIDTH+7)/8)*8-1:0]      s_tdata,  // start_time, end_time
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [M_TDATA_W-1:0]                   m_tdata,  // room_index, rooms_in_use
    output logic [M_TUSER_W-1:0]                   m_tuser   // opened_new, no_room
);

    localparam int M_PAD_W = M_TDATA_W - ROOM_INDEX_W - ROOMS_USE_W;

    queue_ctl_t            q_ctl;
    logic                  q_pop;
    logic [TIME_WIDTH-1:0] q_start;
    logic [TIME_WIDTH-1:0] q_finish;
    result_t               res;

    irff_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_start  (s_tdata[TIME_WIDTH-1:0]),
        .in_finish (s_tdata[2*TIME_WIDTH-1:TIME_WIDTH]),
        .q_pop     (q_pop),
        .q_ctl     (q_ctl),
        .q_start   (q_start),
        .q_finish  (q_finish)
    );

    irff_back #(
        .MAX_ROOMS  (MAX_ROOMS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_ctl     (q_ctl),
        .q_pop     (q_pop),
        .q_start   (q_start),
        .q_finish  (q_finish),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, res.rooms_in_use, res.room_index};
    assign m_tuser = {res.no_room, res.opened_new};

`ifndef NO_ASSERTIONS
    localparam logic [31:0] MAX_WIDE = 32'(MAX_ROOMS);

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |->
            m_tdata[ROOM_INDEX_W-1:0] == '0 && !m_tuser[0] &&
            m_tdata[ROOM_INDEX_W+ROOMS_USE_W-1:ROOM_INDEX_W] == MAX_WIDE[ROOMS_USE_W-1:0])
        else $error("rejected interval without a full room table");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            m_tdata[ROOM_INDEX_W-1:0] ==
            ROOM_INDEX_W'(m_tdata[ROOM_INDEX_W+ROOMS_USE_W-1:ROOM_INDEX_W] - 5'd1))
        else $error("new room is not the last room opened");

    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

>>> tb/interval_room_first_fit_tb.sv
module interval_room_first_fit_tb;
    import irff_pkg::*;

    localparam int MAX_ROOMS    = 16;
    localparam int TIME_WIDTH   = 16;
    localparam int RANDOM_ITEMS = 1200;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLDOFF_AT   = 300;
    localparam int HOLDOFF_LEN  = 300;
    localparam int SENDER_PAUSE = 600;
    localparam int DRAIN_CYCLES = 40;

    class room_scoreboard;
        bit [TIME_WIDTH-1:0] finish_at[MAX_ROOMS];
        int unsigned         open_rooms = 0;
        result_t             expected_rooms[$];
        int                  errors = 0;

        function void note_interval(logic [TIME_WIDTH-1:0] st, logic [TIME_WIDTH-1:0] fin);
            result_t r;
            bit      found;
            int      pick;
            found = 0;
            pick  = 0;
            for (int k = 0; k < MAX_ROOMS; k++) begin
                if (!found && k < open_rooms && st >= finish_at[k]) begin
                    found = 1;
                    pick  = k;
                end
            end
            r.opened_new = 1'b0;
            r.no_room    = 1'b0;
            if (found) begin
                finish_at[pick] = fin;
            end else if (open_rooms < MAX_ROOMS) begin
                pick = open_rooms;
                finish_at[pick] = fin;
                open_rooms++;
                r.opened_new = 1'b1;
            end else begin
                pick = 0;
                r.no_room = 1'b1;
            end
            r.room_index   = pick[ROOM_INDEX_W-1:0];
            r.rooms_in_use = open_rooms[ROOMS_USE_W-1:0];
            expected_rooms.insert(expected_rooms.size(), r);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            result_t want;
            if (expected_rooms.size() == 0) begin
                $error("unexpected result: tdata=%h tuser=%h", tdata, tuser);
                errors++;
                return;
            end
            want = expected_rooms.pop_front();
            if (tdata[ROOM_INDEX_W-1:0] !== want.room_index) begin
                $error("room_index: expected %0d, actual %0d",
                       want.room_index, tdata[ROOM_INDEX_W-1:0]);
                errors++;
            end
            if (tdata[ROOM_INDEX_W +: ROOMS_USE_W] !== want.rooms_in_use) begin
                $error("rooms_in_use: expected %0d, actual %0d",
                       want.rooms_in_use, tdata[ROOM_INDEX_W +: ROOMS_USE_W]);
                errors++;
            end
            if (tuser[0] !== want.opened_new) begin
                $error("opened_new: expected %0d, actual %0d", want.opened_new, tuser[0]);
                errors++;
            end
            if (tuser[1] !== want.no_room) begin
                $error("no_room: expected %0d, actual %0d", want.no_room, tuser[1]);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [2*TIME_WIDTH-1:0] s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    room_scoreboard        rooms_sb;
    int                    results_seen = 0;
    int                    idle_cycles = 0;

    interval_room_first_fit #(
        .MAX_ROOMS (MAX_ROOMS),
        .TIME_WIDTH(TIME_WIDTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_interval(logic [TIME_WIDTH-1:0] st, logic [TIME_WIDTH-1:0] fin);
        s_tdata  = {fin, st};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        rooms_sb.note_interval(st, fin);
        @(negedge aclk);
    endtask

    task automatic idle_sender(int gap);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // receiver: random stalls, one long hold-off, one stretch always ready
    initial begin
        int stall_left;
        bit held;
        stall_left = 0;
        held       = 0;
        m_tready   = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
            end
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                rooms_sb.check_result(m_tdata, m_tuser);
                results_seen++;
                if (!held && results_seen >= HOLDOFF_AT) begin
                    held       = 1;
                    stall_left = HOLDOFF_LEN;
                end else if (results_seen >= 700 && results_seen < 850) begin
                    stall_left = 0;
                end else begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("interval_room_first_fit_tb failed");
            $finish;
        end
    end

    initial begin
        logic [TIME_WIDTH-1:0] st;
        logic [TIME_WIDTH-1:0] fin;
        logic [TIME_WIDTH-1:0] sweep;
        int                    kind;
        rooms_sb       = new();
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // first room, then reuse at the extremes
        send_interval(16'd0, 16'd0);
        send_interval(16'd0, 16'hFFFF);
        // finish before start
        send_interval(16'd100, 16'd50);
        idle_sender(pick_gap());
        // open every remaining room
        for (int k = 2; k < MAX_ROOMS; k++) begin
            send_interval(16'd0, 16'hFFFF);
            idle_sender(pick_gap());
        end
        // table full: reject, then a start equal to room 0's finish reuses room 0
        send_interval(16'd0, 16'd1);
        send_interval(16'hFFFF, 16'hFFFF);
        // out of order starts
        send_interval(16'd50, 16'd7);
        send_interval(16'd7, 16'd0);
        idle_sender(pick_gap());

        sweep = '0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                sweep = sweep + TIME_WIDTH'($urandom_range(0, 600));
                st    = sweep;
                kind  = $urandom_range(0, 99);
                if (kind < 70) begin
                    fin = st + TIME_WIDTH'($urandom_range(1, 2000));
                end else if (kind < 90) begin
                    fin = st + TIME_WIDTH'($urandom_range(0, 40));
                end else begin
                    fin = TIME_WIDTH'($urandom);
                end
            end else begin
                st  = TIME_WIDTH'($urandom);
                fin = TIME_WIDTH'($urandom);
            end
            send_interval(st, fin);
            if (i == SENDER_PAUSE) begin
                s_tvalid = 1'b0;
                while (rooms_sb.expected_rooms.size() != 0) @(negedge aclk);
            end else if (i < 300 || i >= 450) begin
                idle_sender(pick_gap());
            end
        end
        s_tvalid = 1'b0;

        while (rooms_sb.expected_rooms.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (rooms_sb.errors == 0 && rooms_sb.expected_rooms.size() == 0) begin
            $display("interval_room_first_fit_tb passed");
        end else begin
            $display("interval_room_first_fit_tb failed");
        end
        $finish;
    end

endmodule

>>> interval_room_first_fit.f
hw/rtl/irff_pkg.sv
hw/rtl/irff_ram.sv
hw/rtl/irff_front.sv
hw/rtl/irff_back.sv
hw/rtl/interval_room_first_fit.sv
tb/interval_room_first_fit_tb.sv
